@@ rtl/swm_pkg.sv @@
// ============================================================================
// swm_pkg
// Shared constants and controller/datapath interface types for the
// sliding window median filter.
// ============================================================================
package swm_pkg;

   localparam int MAX_WINDOW = 64;
   localparam int IDX_W      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
   localparam int SAMPLE_W   = 32;
   localparam int MEDIAN_W   = 33;
   localparam int WSIZE_W    = 7;

   typedef enum logic [5:0] {
      ST_IDLE    = 6'b000001,
      ST_DROP    = 6'b000010,
      ST_INSERT  = 6'b000100,
      ST_MED_HI  = 6'b001000,
      ST_MED_LO  = 6'b010000,
      ST_MED_SUM = 6'b100000
   } state_type;

   typedef struct packed {
      logic accept;
      logic drop;
      logic insert;
      logic med_hi;
      logic med_lo;
      logic med_sum;
   } cmd_type;

   typedef struct packed {
      logic will_drop;
      logic drop_done;
      logic ins_done;
      logic med_needed;
      logic out_free;
   } status_type;

endpackage

@@ rtl/swm_ram.sv @@
// ============================================================================
// swm_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ============================================================================
module swm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/swm_ctrl.sv @@
// ============================================================================
// swm_ctrl
// Sequencer for one sample: accept, drop the oldest value from the sorted
// store if full, insert the new value, then read and sum the middle entries if full.
// ============================================================================
module swm_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  swm_pkg::status_type status,
   output swm_pkg::cmd_type    cmd
);
   import swm_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = status.will_drop ? ST_DROP : ST_INSERT;
            end
         end
         ST_DROP: begin
            cmd.drop = 1'b1;
            if (status.drop_done) begin
               state_in = ST_INSERT;
            end
         end
         ST_INSERT: begin
            cmd.insert = 1'b1;
            if (status.ins_done) begin
               state_in = status.med_needed ? ST_MED_HI : ST_IDLE;
            end
         end
         ST_MED_HI: begin
            cmd.med_hi = 1'b1;
            state_in   = ST_MED_LO;
         end
         ST_MED_LO: begin
            cmd.med_lo = 1'b1;
            state_in   = ST_MED_SUM;
         end
         ST_MED_SUM: begin
            cmd.med_sum = 1'b1;
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

@@ rtl/swm_datapath.sv @@
// ============================================================================
// swm_datapath
// Window ring, sorted store, fill and pointer bookkeeping, scan counters
// and the median output register.
// ============================================================================
module swm_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [swm_pkg::WSIZE_W-1:0]          csr_wdata,
   input  logic signed [swm_pkg::SAMPLE_W-1:0]  req_sample,
   input  logic                                 req_start_sequence,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [swm_pkg::MEDIAN_W-1:0]  rsp_median_doubled,
   input  swm_pkg::cmd_type                     cmd,
   output swm_pkg::status_type                  status
);
   import swm_pkg::*;

   logic [WSIZE_W-1:0]         window_size_ff;
   logic [CNT_W-1:0]           fill_ff;
   logic [IDX_W-1:0]           ptr_ff;
   logic [CNT_W-1:0]           rd_idx_ff;
   logic [CNT_W-1:0]           didx_ff;
   logic                       dv_ff;
   logic                       found_ff;
   logic                       bottom_ff;
   logic                       rsp_valid_ff;
   logic signed [SAMPLE_W-1:0] sample_ff;
   logic signed [SAMPLE_W-1:0] hi_val_ff;
   logic signed [MEDIAN_W-1:0] median_ff;

   logic [CNT_W-1:0]           w_eff;
   logic [CNT_W-1:0]           fill_eff;
   logic [CNT_W-1:0]           mid_hi;
   logic [CNT_W-1:0]           mid_lo;
   logic [CNT_W:0]             slot_sum;
   logic [CNT_W:0]             slot_wrap;
   logic [IDX_W-1:0]           ptr_inc;
   logic                       out_free;
   logic                       drop_match;
   logic                       drop_done;
   logic                       ins_empty;
   logic                       ins_greater;
   logic                       ins_done;
   logic signed [MEDIAN_W-1:0] median_in;

   logic [SAMPLE_W-1:0]        sorted_rdata_raw;
   logic [SAMPLE_W-1:0]        ring_rdata_raw;
   logic signed [SAMPLE_W-1:0] sorted_rdata;
   logic signed [SAMPLE_W-1:0] ring_rdata;
   logic                       sorted_we;
   logic [IDX_W-1:0]           sorted_waddr;
   logic [SAMPLE_W-1:0]        sorted_wdata;
   logic [IDX_W-1:0]           sorted_raddr;
   logic                       ring_we;
   logic [IDX_W-1:0]           ring_waddr;

   assign sorted_rdata = $signed(sorted_rdata_raw);
   assign ring_rdata   = $signed(ring_rdata_raw);

   // Requested size zero acts as one; sizes past the store depth saturate.
   always_comb begin
      if (window_size_ff == '0) begin
         w_eff = CNT_W'(1);
      end else if (int'(window_size_ff) > MAX_WINDOW) begin
         w_eff = CNT_W'(MAX_WINDOW);
      end else begin
         w_eff = CNT_W'(window_size_ff);
      end
   end

   assign fill_eff = req_start_sequence ? '0 : fill_ff;
   assign mid_hi   = w_eff >> 1;
   assign mid_lo   = w_eff[0] ? mid_hi : (mid_hi - CNT_W'(1));

   assign ptr_inc   = (int'(ptr_ff) == MAX_WINDOW - 1) ? '0 : (ptr_ff + IDX_W'(1));
   assign slot_sum  = {{(CNT_W + 1 - IDX_W){1'b0}}, ptr_ff} + {1'b0, fill_ff};
   assign slot_wrap = (int'(slot_sum) >= MAX_WINDOW) ?
                      (slot_sum - (CNT_W + 1)'(MAX_WINDOW)) : slot_sum;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // The oldest sample always sits in the sorted store, so a match is found
   // by the time the scan reaches the end of the window.
   assign drop_match = dv_ff && !found_ff && (sorted_rdata == ring_rdata);
   assign drop_done  = cmd.drop && dv_ff && (didx_ff == (fill_ff - CNT_W'(1)));

   assign ins_empty   = (fill_ff == '0);
   assign ins_greater = (sorted_rdata > sample_ff);
   assign ins_done    = cmd.insert && (ins_empty || bottom_ff || (dv_ff && !ins_greater));

   assign median_in = MEDIAN_W'(hi_val_ff) + MEDIAN_W'(sorted_rdata);

   always_comb begin
      status.will_drop  = (fill_eff == w_eff);
      status.drop_done  = drop_done;
      status.ins_done   = ins_done;
      status.med_needed = ((fill_ff + CNT_W'(1)) == w_eff);
      status.out_free   = out_free;
   end

   // Sorted store port control. The drop scan shifts entries down behind the
   // read pointer; the insert scan shifts entries up behind it.
   always_comb begin
      sorted_we    = 1'b0;
      sorted_waddr = '0;
      sorted_wdata = sorted_rdata_raw;
      if (cmd.drop) begin
         if (dv_ff && found_ff) begin
            sorted_we    = 1'b1;
            sorted_waddr = IDX_W'(didx_ff - CNT_W'(1));
         end
      end else if (cmd.insert) begin
         if (ins_empty || bottom_ff) begin
            sorted_we    = 1'b1;
            sorted_waddr = '0;
            sorted_wdata = sample_ff;
         end else if (dv_ff) begin
            sorted_we    = 1'b1;
            sorted_waddr = IDX_W'(didx_ff + CNT_W'(1));
            sorted_wdata = ins_greater ? sorted_rdata_raw : sample_ff;
         end
      end
   end

   always_comb begin
      if (cmd.drop || cmd.insert) begin
         sorted_raddr = rd_idx_ff[IDX_W-1:0];
      end else if (cmd.med_lo || cmd.med_sum) begin
         sorted_raddr = mid_lo[IDX_W-1:0];
      end else if (cmd.med_hi) begin
         sorted_raddr = mid_hi[IDX_W-1:0];
      end else begin
         sorted_raddr = '0;
      end
   end

   assign ring_we    = ins_done;
   assign ring_waddr = slot_wrap[IDX_W-1:0];

   swm_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (MAX_WINDOW)
   ) u_sorted_ram (
      .clock   (clock),
      .wr_en   (sorted_we),
      .wr_addr (sorted_waddr),
      .wr_data (sorted_wdata),
      .rd_addr (sorted_raddr),
      .rd_data (sorted_rdata_raw)
   );

   // The ring is read at the oldest slot continuously, so its data is ready
   // by the time the drop scan starts comparing.
   swm_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (MAX_WINDOW)
   ) u_ring_ram (
      .clock   (clock),
      .wr_en   (ring_we),
      .wr_addr (ring_waddr),
      .wr_data (sample_ff),
      .rd_addr (ptr_ff),
      .rd_data (ring_rdata_raw)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff <= WSIZE_W'(1);
         fill_ff        <= '0;
         ptr_ff         <= '0;
         rd_idx_ff      <= '0;
         didx_ff        <= '0;
         dv_ff          <= 1'b0;
         found_ff       <= 1'b0;
         bottom_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            window_size_ff <= csr_wdata;
            fill_ff        <= '0;
            ptr_ff         <= '0;
         end
         if (cmd.accept) begin
            fill_ff   <= fill_eff;
            if (req_start_sequence) begin
               ptr_ff <= '0;
            end
            rd_idx_ff <= status.will_drop ? '0 : (fill_eff - CNT_W'(1));
            dv_ff     <= 1'b0;
            found_ff  <= 1'b0;
            bottom_ff <= 1'b0;
         end
         if (cmd.drop) begin
            rd_idx_ff <= rd_idx_ff + CNT_W'(1);
            didx_ff   <= rd_idx_ff;
            dv_ff     <= 1'b1;
            if (drop_match) begin
               found_ff <= 1'b1;
            end
            if (drop_done) begin
               fill_ff   <= fill_ff - CNT_W'(1);
               ptr_ff    <= ptr_inc;
               rd_idx_ff <= fill_ff - CNT_W'(2);
               dv_ff     <= 1'b0;
               found_ff  <= 1'b0;
               bottom_ff <= 1'b0;
            end
         end
         if (cmd.insert) begin
            rd_idx_ff <= rd_idx_ff - CNT_W'(1);
            didx_ff   <= rd_idx_ff;
            dv_ff     <= 1'b1;
            if (dv_ff && ins_greater && (didx_ff == '0)) begin
               bottom_ff <= 1'b1;
            end
            if (ins_done) begin
               fill_ff   <= fill_ff + CNT_W'(1);
               dv_ff     <= 1'b0;
               bottom_ff <= 1'b0;
            end
         end
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.med_sum && out_free) begin
            rsp_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         sample_ff <= req_sample;
      end
      if (cmd.med_lo) begin
         hi_val_ff <= sorted_rdata;
      end
      if (cmd.med_sum && out_free) begin
         median_ff <= median_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_median_doubled = median_ff;

   a_fill_bounded : assert property (@(posedge clock) disable iff (reset)
      fill_ff <= w_eff)
      else $error("fill count exceeds the window size");

   a_drop_found : assert property (@(posedge clock) disable iff (reset)
      drop_done |-> (found_ff || drop_match))
      else $error("drop scan ended without finding the oldest sample");

   a_insert_index : assert property (@(posedge clock) disable iff (reset)
      (cmd.insert && dv_ff && !bottom_ff) |-> (didx_ff < fill_ff))
      else $error("insert scan index outside the filled window");

endmodule

@@ rtl/sliding_window_median.sv @@
// ============================================================================
// sliding_window_median
// Running median over the most recent window_size samples of a signed
// stream; the result is twice the median, i.e. the median with one fraction bit.
// ============================================================================
//
//   Channel  Ports                                      Direction
//   req      req_valid/req_stall, sample, start_seq     in  (stall driven out)
//   rsp      rsp_valid/rsp_stall, median_doubled        out (stall driven in)
//   csr      csr_we, csr_wdata (window_size)            in, write only
//
// A sample takes longer as the window fills; the linear drop and insert
// scans over the sorted store set the time, and req_stall holds off the next
// sample until the current one is done.
// Reset is synchronous; no clearing pass runs, the stores need none.
// A finished result waits in the output register while the next beat is taken.
// ============================================================================
module sliding_window_median (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [swm_pkg::WSIZE_W-1:0]          csr_wdata,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [swm_pkg::SAMPLE_W-1:0]  req_sample,
   input  logic                                 req_start_sequence,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [swm_pkg::MEDIAN_W-1:0]  rsp_median_doubled
);
   import swm_pkg::*;

   cmd_type    cmd;
   status_type status;

   swm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   swm_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_wdata          (csr_wdata),
      .req_sample         (req_sample),
      .req_start_sequence (req_start_sequence),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_median_doubled (rsp_median_doubled),
      .cmd                (cmd),
      .status             (status)
   );

endmodule
